FILE: rtl/rsi_pkg.sv
// rsi_pkg: widths, register codes and pipeline stage types for the
// ray/sphere intersection block. No dependencies.
package rsi_pkg;

  localparam int CW = 32;                 // coordinate width
  localparam int FB = 16;                 // fraction bits
  localparam int T_W = CW - 1;            // distance / radius width
  localparam int E_W = CW + 1;            // origin minus centre
  localparam int A_W = 2 * CW;            // d.d
  localparam int H_W = 2 * CW + 2;        // d.e, signed
  localparam int HABS_W = H_W - 1;
  localparam int C_W = 2 * CW + 3;        // e.e - r*r, signed
  localparam int CP_W = C_W - 1;          // positive part of C
  localparam int HL_W = HABS_W - CW;      // low split of |H|
  localparam int CL_W = CP_W / 2;         // low split of C
  localparam int AL_W = A_W / 2;          // low split of A
  localparam int P_W = 2 * HABS_W;        // H*H and A*C
  localparam int ROOT_W = (P_W + 2) / 2;  // one root bit per cell
  localparam int SQ_IN_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;
  localparam int Q_W = ROOT_W + 1;
  localparam int DIV_W = Q_W + T_W;       // den << T_W fits
  localparam logic [T_W-1:0] T_MAX = '1;
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_CENTRE_X,
    REG_CENTRE_Y,
    REG_CENTRE_Z,
    REG_RADIUS
  } reg_idx_t;

  typedef struct packed {
    logic                valid;
    logic                ok;
    logic [HABS_W-1:0]   habs;
    logic [A_W-1:0]      a;
    logic [CP_W-1:0]     cp;
    logic [SQ_IN_W-1:0]  rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
  } sq_stage_t;

  typedef struct packed {
    logic              valid;
    logic              ok;
    logic              sat;
    logic [DIV_W-1:0]  rem;
    logic [DIV_W-1:0]  den;
    logic [T_W-1:0]    quot;
  } div_stage_t;

endpackage

FILE: rtl/ray_sphere_intersect.sv
// Throughput: one item per cycle; busy stays low. The pipeline holds 7 front
// stages, 66 square-root cells, 2 setup stages, 31 divider cells in each of
// the two divider chains and the output register.
// Reset (synchronous, rst_n low) clears all valid bits and loads the
// sphere: centre 0, radius 1.0. Results cannot be stalled.
module ray_sphere_intersect (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [rsi_pkg::CW-1:0]    in_origin_x,
  input  logic signed [rsi_pkg::CW-1:0]    in_origin_y,
  input  logic signed [rsi_pkg::CW-1:0]    in_origin_z,
  input  logic signed [rsi_pkg::CW-1:0]    in_dir_x,
  input  logic signed [rsi_pkg::CW-1:0]    in_dir_y,
  input  logic signed [rsi_pkg::CW-1:0]    in_dir_z,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [rsi_pkg::T_W-1:0]          out_hit_distance,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rsi_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int CW = rsi_pkg::CW;
  localparam int E_W = rsi_pkg::E_W;
  localparam int T_W = rsi_pkg::T_W;

  // ---------------- configuration ----------------
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic [T_W-1:0] rad_r;
  logic wr_en;

  assign pready = 1'b1;
  assign busy = 1'b0;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
      rad_r <= T_W'(1) << rsi_pkg::FB;
    end else if (wr_en) begin
      unique case (rsi_pkg::reg_idx_t'(paddr[3:2]))
        rsi_pkg::REG_CENTRE_X: cx_r <= pwdata;
        rsi_pkg::REG_CENTRE_Y: cy_r <= pwdata;
        rsi_pkg::REG_CENTRE_Z: cz_r <= pwdata;
        rsi_pkg::REG_RADIUS:   rad_r <= pwdata[T_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (rsi_pkg::reg_idx_t'(paddr[3:2]))
      rsi_pkg::REG_CENTRE_X: prdata = cx_r;
      rsi_pkg::REG_CENTRE_Y: prdata = cy_r;
      rsi_pkg::REG_CENTRE_Z: prdata = cz_r;
      rsi_pkg::REG_RADIUS:   prdata = {1'b0, rad_r};
      default:               prdata = '0;
    endcase
  end

  // ---------------- S1: e = o - centre ----------------
  logic s1_v_r;
  logic signed [E_W-1:0] s1_e_r [3];
  logic signed [CW-1:0] s1_d_r [3];

  always_ff @(posedge clk) begin
    s1_v_r <= rst_n && start;
    s1_e_r[0] <= {in_origin_x[CW-1], in_origin_x} - {cx_r[CW-1], cx_r};
    s1_e_r[1] <= {in_origin_y[CW-1], in_origin_y} - {cy_r[CW-1], cy_r};
    s1_e_r[2] <= {in_origin_z[CW-1], in_origin_z} - {cz_r[CW-1], cz_r};
    s1_d_r[0] <= in_dir_x;
    s1_d_r[1] <= in_dir_y;
    s1_d_r[2] <= in_dir_z;
  end

  // ---------------- S2: component products ----------------
  logic s2_v_r;
  logic signed [2*CW-1:0] s2_dd_r [3];
  logic signed [2*CW:0]   s2_de_r [3];
  logic signed [2*CW+1:0] s2_ee_r [3];
  logic [2*T_W-1:0] s2_rr_r;

  always_ff @(posedge clk) begin
    s2_v_r <= rst_n && s1_v_r;
    for (int i = 0; i < 3; i++) begin
      s2_dd_r[i] <= s1_d_r[i] * s1_d_r[i];
      s2_de_r[i] <= s1_d_r[i] * s1_e_r[i];
      s2_ee_r[i] <= s1_e_r[i] * s1_e_r[i];
    end
    s2_rr_r <= rad_r * rad_r;
  end

  // ---------------- S3: A, H, C ----------------
  logic s3_v_r;
  logic [rsi_pkg::A_W-1:0] s3_a_r;
  logic signed [rsi_pkg::H_W-1:0] s3_h_r;
  logic signed [rsi_pkg::C_W-1:0] s3_c_r;

  always_ff @(posedge clk) begin
    s3_v_r <= rst_n && s2_v_r;
    s3_a_r <= s2_dd_r[0][rsi_pkg::A_W-1:0] + s2_dd_r[1][rsi_pkg::A_W-1:0]
            + s2_dd_r[2][rsi_pkg::A_W-1:0];
    s3_h_r <= rsi_pkg::H_W'(s2_de_r[0]) + rsi_pkg::H_W'(s2_de_r[1])
            + rsi_pkg::H_W'(s2_de_r[2]);
    s3_c_r <= rsi_pkg::C_W'(s2_ee_r[0]) + rsi_pkg::C_W'(s2_ee_r[1])
            + rsi_pkg::C_W'(s2_ee_r[2]) - rsi_pkg::C_W'(s2_rr_r);
  end

  // ---------------- S4: |H|, positive C, early miss ----------------
  // A hit needs H < 0 (else Q <= 0), C > 0 and A != 0.
  logic s4_v_r, s4_ok_r;
  logic [rsi_pkg::HABS_W-1:0] s4_habs_r;
  logic [rsi_pkg::A_W-1:0] s4_a_r;
  logic [rsi_pkg::CP_W-1:0] s4_cp_r;
  logic h_neg, c_pos;
  logic signed [rsi_pkg::H_W-1:0] h_abs_full;

  always_comb begin
    h_neg = s3_h_r[rsi_pkg::H_W-1];
    c_pos = !s3_c_r[rsi_pkg::C_W-1] && (s3_c_r != '0);
    h_abs_full = h_neg ? -s3_h_r : s3_h_r;
  end

  always_ff @(posedge clk) begin
    s4_v_r <= rst_n && s3_v_r;
    s4_ok_r <= (s3_a_r != '0) && h_neg && c_pos;
    s4_habs_r <= h_abs_full[rsi_pkg::HABS_W-1:0];
    s4_a_r <= s3_a_r;
    s4_cp_r <= c_pos ? s3_c_r[rsi_pkg::CP_W-1:0] : '0;
  end

  // ---------------- S5: partial products of H*H and A*C ----------------
  localparam int HL_W = rsi_pkg::HL_W;
  localparam int CL_W = rsi_pkg::CL_W;
  localparam int AL_W = rsi_pkg::AL_W;
  localparam int P_W = rsi_pkg::P_W;

  logic s5_v_r, s5_ok_r;
  logic [rsi_pkg::HABS_W-1:0] s5_habs_r;
  logic [rsi_pkg::A_W-1:0] s5_a_r;
  logic [rsi_pkg::CP_W-1:0] s5_cp_r;
  logic [2*CW-1:0] s5_hh2_r;
  logic [CW+HL_W-1:0] s5_hx_r;
  logic [2*HL_W-1:0] s5_hl2_r;
  logic [AL_W+CL_W-1:0] s5_ahch_r, s5_ahcl_r, s5_alch_r, s5_alcl_r;

  always_ff @(posedge clk) begin
    s5_v_r <= rst_n && s4_v_r;
    s5_ok_r <= s4_ok_r;
    s5_habs_r <= s4_habs_r;
    s5_a_r <= s4_a_r;
    s5_cp_r <= s4_cp_r;
    s5_hh2_r <= s4_habs_r[rsi_pkg::HABS_W-1:HL_W] * s4_habs_r[rsi_pkg::HABS_W-1:HL_W];
    s5_hx_r <= s4_habs_r[rsi_pkg::HABS_W-1:HL_W] * s4_habs_r[HL_W-1:0];
    s5_hl2_r <= s4_habs_r[HL_W-1:0] * s4_habs_r[HL_W-1:0];
    s5_ahch_r <= s4_a_r[rsi_pkg::A_W-1:AL_W] * s4_cp_r[rsi_pkg::CP_W-1:CL_W];
    s5_ahcl_r <= s4_a_r[rsi_pkg::A_W-1:AL_W] * s4_cp_r[CL_W-1:0];
    s5_alch_r <= s4_a_r[AL_W-1:0] * s4_cp_r[rsi_pkg::CP_W-1:CL_W];
    s5_alcl_r <= s4_a_r[AL_W-1:0] * s4_cp_r[CL_W-1:0];
  end

  // ---------------- S6: H*H and A*C ----------------
  logic s6_v_r, s6_ok_r;
  logic [rsi_pkg::HABS_W-1:0] s6_habs_r;
  logic [rsi_pkg::A_W-1:0] s6_a_r;
  logic [rsi_pkg::CP_W-1:0] s6_cp_r;
  logic [P_W-1:0] s6_h2_r, s6_ac_r;

  always_ff @(posedge clk) begin
    s6_v_r <= rst_n && s5_v_r;
    s6_ok_r <= s5_ok_r;
    s6_habs_r <= s5_habs_r;
    s6_a_r <= s5_a_r;
    s6_cp_r <= s5_cp_r;
    s6_h2_r <= (P_W'(s5_hh2_r) << (2 * HL_W)) + (P_W'(s5_hx_r) << (HL_W + 1))
             + P_W'(s5_hl2_r);
    s6_ac_r <= (P_W'(s5_ahch_r) << (AL_W + CL_W)) + (P_W'(s5_ahcl_r) << AL_W)
             + (P_W'(s5_alch_r) << CL_W) + P_W'(s5_alcl_r);
  end

  // ---------------- S7: discriminant, square-root input ----------------
  logic [P_W:0] disc;
  rsi_pkg::sq_stage_t sq0_r;

  assign disc = {1'b0, s6_h2_r} - {1'b0, s6_ac_r};

  always_ff @(posedge clk) begin
    sq0_r.valid <= rst_n && s6_v_r;
    sq0_r.ok <= s6_ok_r && !disc[P_W];
    sq0_r.habs <= s6_habs_r;
    sq0_r.a <= s6_a_r;
    sq0_r.cp <= s6_cp_r;
    sq0_r.rad <= disc[P_W] ? '0 : rsi_pkg::SQ_IN_W'(disc[P_W-1:0]);
    sq0_r.rem <= '0;
    sq0_r.root <= '0;
  end

  // ---------------- square-root chain ----------------
  rsi_pkg::sq_stage_t sq_out [rsi_pkg::ROOT_W];

  for (genvar k = 0; k < rsi_pkg::ROOT_W; k++) begin : g_sqrt
    rsi_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i ((k == 0) ? sq0_r : sq_out[(k == 0) ? 0 : k - 1]),
      .stage_o (sq_out[k])
    );
  end

  rsi_pkg::sq_stage_t sq_last;
  assign sq_last = sq_out[rsi_pkg::ROOT_W-1];

  // ---------------- Q = |H| + S ----------------
  localparam int Q_W = rsi_pkg::Q_W;
  localparam int DIV_W = rsi_pkg::DIV_W;

  logic q_v_r, q_ok_r;
  logic [Q_W-1:0] q_r;
  logic [rsi_pkg::A_W-1:0] q_a_r;
  logic [rsi_pkg::CP_W-1:0] q_cp_r;

  always_ff @(posedge clk) begin
    q_v_r <= rst_n && sq_last.valid;
    q_ok_r <= sq_last.ok;
    q_r <= Q_W'(sq_last.habs) + Q_W'(sq_last.root);
    q_a_r <= sq_last.a;
    q_cp_r <= sq_last.cp;
  end

  // ---------------- divider setup: t0 = Q/A, t1 = C/Q ----------------
  logic [DIV_W-1:0] num0, den0, num1, den1;
  rsi_pkg::div_stage_t dv0_r, dv1_r;

  always_comb begin
    num0 = DIV_W'({q_r, {rsi_pkg::FB{1'b0}}});
    den0 = DIV_W'(q_a_r);
    num1 = DIV_W'({q_cp_r, {rsi_pkg::FB{1'b0}}});
    den1 = DIV_W'(q_r);
  end

  always_ff @(posedge clk) begin
    dv0_r.valid <= rst_n && q_v_r;
    dv0_r.ok <= q_ok_r;
    dv0_r.sat <= num0 >= (den0 << T_W);
    dv0_r.rem <= num0;
    dv0_r.den <= den0 << (T_W - 1);
    dv0_r.quot <= '0;
    dv1_r.valid <= rst_n && q_v_r;
    dv1_r.ok <= q_ok_r;
    dv1_r.sat <= num1 >= (den1 << T_W);
    dv1_r.rem <= num1;
    dv1_r.den <= den1 << (T_W - 1);
    dv1_r.quot <= '0;
  end

  // ---------------- divider chains ----------------
  rsi_pkg::div_stage_t dv0_out [T_W];
  rsi_pkg::div_stage_t dv1_out [T_W];

  for (genvar k = 0; k < T_W; k++) begin : g_div
    rsi_div_cell u_cell0 (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i ((k == 0) ? dv0_r : dv0_out[(k == 0) ? 0 : k - 1]),
      .stage_o (dv0_out[k])
    );
    rsi_div_cell u_cell1 (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i ((k == 0) ? dv1_r : dv1_out[(k == 0) ? 0 : k - 1]),
      .stage_o (dv1_out[k])
    );
  end

  // ---------------- nearer root, output register ----------------
  rsi_pkg::div_stage_t f0, f1;
  logic [T_W-1:0] t0, t1, t_min;
  logic out_valid_r, out_hit_r;
  logic [T_W-1:0] out_dist_r;

  always_comb begin
    f0 = dv0_out[T_W-1];
    f1 = dv1_out[T_W-1];
    t0 = f0.sat ? rsi_pkg::T_MAX : f0.quot;
    t1 = f1.sat ? rsi_pkg::T_MAX : f1.quot;
    t_min = (t0 < t1) ? t0 : t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_hit_r <= 1'b0;
      out_dist_r <= '0;
    end else begin
      out_valid_r <= f0.valid;
      out_hit_r <= f0.ok && f1.ok && (t_min != '0);
      out_dist_r <= (f0.ok && f1.ok) ? t_min : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit = out_hit_r;
  assign out_hit_distance = out_dist_r;

  // ---------------- assertions ----------------
  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_hit_distance != '0)
    else $error("hit reported with zero distance");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_distance == '0)
    else $error("miss reported with nonzero distance");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    f0.valid == f1.valid)
    else $error("divider chains out of step");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sq_last.valid |-> sq_last.rem <= rsi_pkg::REM_W'({sq_last.root, 1'b0}))
    else $error("square root remainder out of range");

endmodule

FILE: rtl/rsi_sqrt_cell.sv
// rsi_sqrt_cell: one bit of a digit-by-digit integer square root.
// Depends on rsi_pkg.
module rsi_sqrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  rsi_pkg::sq_stage_t  stage_i,
  output rsi_pkg::sq_stage_t  stage_o
);

  rsi_pkg::sq_stage_t stage_r, stage_nxt;
  logic [rsi_pkg::REM_W-1:0] cur, trial;
  logic ge;

  always_comb begin
    cur = {stage_i.rem[rsi_pkg::REM_W-3:0],
           stage_i.rad[rsi_pkg::SQ_IN_W-1 -: 2]};
    trial = rsi_pkg::REM_W'({stage_i.root, 2'b01});
    ge = (cur >= trial);
    stage_nxt = stage_i;
    stage_nxt.valid = rst_n && stage_i.valid;
    stage_nxt.rad = stage_i.rad << 2;
    stage_nxt.rem = ge ? (cur - trial) : cur;
    stage_nxt.root = {stage_i.root[rsi_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign stage_o = stage_r;

endmodule

FILE: rtl/rsi_div_cell.sv
// rsi_div_cell: one quotient bit of a restoring divider; the divisor
// arrives pre-shifted and moves right one place per cell. Depends on rsi_pkg.
module rsi_div_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rsi_pkg::div_stage_t  stage_i,
  output rsi_pkg::div_stage_t  stage_o
);

  rsi_pkg::div_stage_t stage_r, stage_nxt;
  logic ge;

  always_comb begin
    ge = (stage_i.rem >= stage_i.den);
    stage_nxt = stage_i;
    stage_nxt.valid = rst_n && stage_i.valid;
    stage_nxt.rem = ge ? (stage_i.rem - stage_i.den) : stage_i.rem;
    stage_nxt.den = stage_i.den >> 1;
    stage_nxt.quot = {stage_i.quot[rsi_pkg::T_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign stage_o = stage_r;

endmodule
